[src/mlru_pkg.sv]
// ----------------------------------------------------------------------------
// mlru_pkg
// Shared types and constants of the midpoint LRU frame manager.
// ----------------------------------------------------------------------------
package mlru_pkg;

  localparam logic [6:0]  PCT_MAX     = 7'd100;
  localparam logic [6:0]  PCT_RESET   = 7'd37;
  localparam logic [31:0] LOG_STEP    = 32'd10;
  localparam logic [7:0]  PIN_MAX     = 8'd255;
  localparam logic [12:0] RECIP_MUL   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LK_CHK,
    ST_HIT_WR,
    ST_FIND,
    ST_MISS,
    ST_V1_RD,
    ST_V1_CHK,
    ST_V2_RD,
    ST_V2_CHK,
    ST_EVICT,
    ST_INSTALL,
    ST_UF_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic idx_zero;
    logic idx_len;
    logic idx_inc;
    logic fsel_idx;
    logic fsel_list;
    logic fsel_fidx;
    logic fsel_free;
    logic hit_upd;
    logic move_front;
    logic evict;
    logic install;
    logic unfix_upd;
    logic res_fail;
  } cmd_t;

  typedef struct packed {
    logic unfix;
    logic uf_ok;
    logic match;
    logic idx_end;
    logic frame_old;
    logic list_match;
    logic free_avail;
    logic len_gt_mid;
    logic len_zero;
    logic idx_gt_mid;
    logic idx_zero;
    logic pins_zero;
  } sts_t;

endpackage

[src/mlru_ram.sv]
// ----------------------------------------------------------------------------
// mlru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/mlru_ctrl.sv]
// ----------------------------------------------------------------------------
// mlru_ctrl
// Sequencer for lookup, victim scan, list update and unfix.
// ----------------------------------------------------------------------------
module mlru_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  input  mlru_pkg::sts_t sts,
  output mlru_pkg::cmd_t cmd
);

  mlru_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlru_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != mlru_pkg::ST_IDLE);
    done       = 1'b0;
    case (state)
      mlru_pkg::ST_IDLE: begin
        if (start) begin
          cmd.latch    = 1'b1;
          cmd.idx_zero = 1'b1;
          state_next   = mlru_pkg::ST_DISPATCH;
        end
      end
      mlru_pkg::ST_DISPATCH: begin
        if (sts.unfix) begin
          if (sts.uf_ok) begin
            cmd.fsel_fidx = 1'b1;
            state_next    = mlru_pkg::ST_UF_WR;
          end else begin
            state_next = mlru_pkg::ST_DONE;
          end
        end else begin
          cmd.fsel_idx = 1'b1;
          state_next   = mlru_pkg::ST_LK_CHK;
        end
      end
      mlru_pkg::ST_LK_CHK: begin
        if (sts.match) begin
          state_next = mlru_pkg::ST_HIT_WR;
        end else if (sts.idx_end) begin
          state_next = mlru_pkg::ST_MISS;
        end else begin
          cmd.fsel_idx = 1'b1;
        end
      end
      mlru_pkg::ST_HIT_WR: begin
        cmd.hit_upd = 1'b1;
        if (sts.frame_old) begin
          cmd.idx_zero = 1'b1;
          state_next   = mlru_pkg::ST_FIND;
        end else begin
          state_next = mlru_pkg::ST_DONE;
        end
      end
      mlru_pkg::ST_FIND: begin
        if (sts.list_match) begin
          cmd.move_front = 1'b1;
          state_next     = mlru_pkg::ST_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      mlru_pkg::ST_MISS: begin
        if (sts.free_avail) begin
          cmd.fsel_free = 1'b1;
          state_next    = mlru_pkg::ST_INSTALL;
        end else if (sts.len_gt_mid) begin
          cmd.idx_len = 1'b1;
          state_next  = mlru_pkg::ST_V1_RD;
        end else if (!sts.len_zero) begin
          cmd.idx_len = 1'b1;
          state_next  = mlru_pkg::ST_V2_RD;
        end else begin
          cmd.res_fail = 1'b1;
          state_next   = mlru_pkg::ST_DONE;
        end
      end
      mlru_pkg::ST_V1_RD: begin
        cmd.fsel_list = 1'b1;
        state_next    = mlru_pkg::ST_V1_CHK;
      end
      mlru_pkg::ST_V1_CHK: begin
        if (sts.pins_zero) begin
          state_next = mlru_pkg::ST_EVICT;
        end else if (sts.idx_gt_mid) begin
          cmd.fsel_list = 1'b1;
        end else begin
          cmd.idx_len = 1'b1;
          state_next  = mlru_pkg::ST_V2_RD;
        end
      end
      mlru_pkg::ST_V2_RD: begin
        cmd.fsel_list = 1'b1;
        state_next    = mlru_pkg::ST_V2_CHK;
      end
      mlru_pkg::ST_V2_CHK: begin
        if (sts.pins_zero) begin
          state_next = mlru_pkg::ST_EVICT;
        end else if (!sts.idx_zero) begin
          cmd.fsel_list = 1'b1;
        end else begin
          cmd.res_fail = 1'b1;
          state_next   = mlru_pkg::ST_DONE;
        end
      end
      mlru_pkg::ST_EVICT: begin
        cmd.evict  = 1'b1;
        state_next = mlru_pkg::ST_INSTALL;
      end
      mlru_pkg::ST_INSTALL: begin
        cmd.install = 1'b1;
        state_next  = mlru_pkg::ST_DONE;
      end
      mlru_pkg::ST_UF_WR: begin
        cmd.unfix_upd = 1'b1;
        state_next    = mlru_pkg::ST_DONE;
      end
      mlru_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = mlru_pkg::ST_IDLE;
      end
      default: begin
        state_next = mlru_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[src/mlru_dp.sv]
// ----------------------------------------------------------------------------
// mlru_dp
// Frame tables, recency list, free count, log counter and result registers.
// ----------------------------------------------------------------------------
module mlru_dp #(
  parameter int POOL_FRAMES = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           kind,
  input  logic [30:0]    page_id,
  input  logic [3:0]     unfix_frame,
  input  logic           mark_dirty,
  input  logic           old_percent_we,
  input  logic [6:0]     old_percent,
  input  mlru_pkg::cmd_t cmd,
  output mlru_pkg::sts_t sts,
  output logic [3:0]     frame,
  output logic           hit,
  output logic           failed,
  output logic           evicted,
  output logic [30:0]    evicted_page,
  output logic           wrote_back,
  output logic [31:0]    log_number
);

  localparam int FW = $clog2(POOL_FRAMES);
  localparam int IW = $clog2(POOL_FRAMES + 1);
  localparam int PW = $clog2(POOL_FRAMES * 100 + 1);
  localparam int SW = PW + 13;
  localparam logic [IW-1:0] P_IW  = IW'(POOL_FRAMES);
  localparam logic [IW-1:0] EMPTY = IW'(POOL_FRAMES);

  logic [6:0]    old_pct;
  logic [6:0]    pct_c;
  logic [6:0]    pct_diff;
  logic [PW-1:0] prod;
  logic [SW-1:0] scaled;
  logic [IW-1:0] mid;

  logic          kind_r;
  logic [30:0]   pid_r;
  logic [3:0]    fidx_r;
  logic          mark_r;

  logic [IW-1:0] order_list [POOL_FRAMES];
  logic [IW-1:0] len;
  logic [IW-1:0] free_count;
  logic [IW-1:0] idx;
  logic [IW-1:0] idx_m1;
  logic [IW-1:0] free_frame;
  logic [IW-1:0] ins_pos;
  logic [FW-1:0] fsel;
  logic [FW-1:0] fsel_next;
  logic [FW+3:0] fidx_ext;
  logic [FW+3:0] fsel_ext;
  logic [IW-1:0] list_at_idx;
  logic [IW-1:0] list_at_m1;
  logic [31:0]   log_counter;
  logic [31:0]   log_inc;

  logic [POOL_FRAMES-1:0] frame_valid;
  logic [POOL_FRAMES-1:0] frame_dirty;
  logic [POOL_FRAMES-1:0] frame_old;

  logic          page_we;
  logic [30:0]   page_rdata;
  logic          pins_we;
  logic [7:0]    pins_wdata;
  logic [7:0]    pins_rdata;

  assign pct_c    = (old_pct > mlru_pkg::PCT_MAX) ? mlru_pkg::PCT_MAX : old_pct;
  assign pct_diff = mlru_pkg::PCT_MAX - pct_c;
  assign mid      = IW'(scaled >> mlru_pkg::RECIP_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      old_pct <= mlru_pkg::PCT_RESET;
    end else if (old_percent_we) begin
      old_pct <= old_percent;
    end
    prod   <= PW'(pct_diff) * PW'(POOL_FRAMES);
    scaled <= SW'(prod) * SW'(mlru_pkg::RECIP_MUL);
  end

  assign idx_m1      = idx - 1'b1;
  assign free_frame  = P_IW - free_count;
  assign ins_pos     = (mid < len) ? mid : len;
  assign fidx_ext    = {{FW{1'b0}}, fidx_r};
  assign fsel_ext    = {4'b0000, fsel};
  assign list_at_idx = order_list[idx[FW-1:0]];
  assign list_at_m1  = order_list[idx_m1[FW-1:0]];
  assign log_inc     = log_counter + mlru_pkg::LOG_STEP;

  always_comb begin
    fsel_next = fsel;
    if (cmd.fsel_idx) begin
      fsel_next = idx[FW-1:0];
    end else if (cmd.fsel_list) begin
      fsel_next = list_at_m1[FW-1:0];
    end else if (cmd.fsel_fidx) begin
      fsel_next = fidx_ext[FW-1:0];
    end else if (cmd.fsel_free) begin
      fsel_next = free_frame[FW-1:0];
    end
  end

  assign page_we = cmd.install;

  always_comb begin
    pins_we    = cmd.hit_upd | cmd.install | cmd.unfix_upd;
    pins_wdata = 8'd1;
    if (cmd.hit_upd) begin
      pins_wdata = (pins_rdata == mlru_pkg::PIN_MAX) ? pins_rdata : pins_rdata + 8'd1;
    end else if (cmd.unfix_upd) begin
      pins_wdata = (pins_rdata == 8'd0) ? pins_rdata : pins_rdata - 8'd1;
    end
  end

  mlru_ram #(.WIDTH(31), .DEPTH(POOL_FRAMES)) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (fsel),
    .wdata (pid_r),
    .raddr (fsel_next),
    .rdata (page_rdata)
  );

  mlru_ram #(.WIDTH(8), .DEPTH(POOL_FRAMES)) u_pins_ram (
    .clk   (clk),
    .we    (pins_we),
    .waddr (fsel),
    .wdata (pins_wdata),
    .raddr (fsel_next),
    .rdata (pins_rdata)
  );

  always_comb begin
    sts.unfix      = kind_r;
    sts.uf_ok      = (fidx_ext < (FW + 4)'(POOL_FRAMES)) && frame_valid[fidx_ext[FW-1:0]];
    sts.match      = frame_valid[fsel] && (page_rdata == pid_r);
    sts.idx_end    = (idx == P_IW);
    sts.frame_old  = frame_old[fsel];
    sts.list_match = (list_at_idx == IW'(fsel));
    sts.free_avail = (free_count != '0);
    sts.len_gt_mid = (len > mid);
    sts.len_zero   = (len == '0);
    sts.idx_gt_mid = (idx > mid);
    sts.idx_zero   = (idx == '0);
    sts.pins_zero  = (pins_rdata == 8'd0);
  end

  always_ff @(posedge clk) begin
    fsel <= fsel_next;
    if (cmd.latch) begin
      kind_r <= kind;
      pid_r  <= page_id;
      fidx_r <= unfix_frame;
      mark_r <= mark_dirty;
    end
    if (cmd.idx_zero) begin
      idx <= '0;
    end else if (cmd.idx_len) begin
      idx <= len;
    end else if (cmd.idx_inc || cmd.fsel_idx) begin
      idx <= idx + 1'b1;
    end else if (cmd.fsel_list) begin
      idx <= idx_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < POOL_FRAMES; j++) begin
        order_list[j] <= EMPTY;
      end
      len         <= '0;
      free_count  <= P_IW;
      log_counter <= '0;
      frame_valid <= '0;
      frame_dirty <= '0;
      frame_old   <= '0;
    end else begin
      if (cmd.fsel_free) begin
        free_count <= free_count - 1'b1;
      end
      if (cmd.hit_upd) begin
        frame_old[fsel] <= 1'b0;
      end
      if (cmd.move_front) begin
        for (int j = 0; j < POOL_FRAMES; j++) begin
          if (j == 0) begin
            order_list[j] <= IW'(fsel);
          end else if (IW'(j) <= idx) begin
            order_list[j] <= order_list[j-1];
          end
        end
      end
      if (cmd.evict) begin
        for (int j = 0; j < POOL_FRAMES; j++) begin
          if (IW'(j) >= idx) begin
            order_list[j] <= (j == POOL_FRAMES - 1) ? EMPTY
                             : order_list[(j + 1) % POOL_FRAMES];
          end
        end
        len <= len - 1'b1;
        if (frame_dirty[fsel]) begin
          log_counter <= log_inc;
        end
      end
      if (cmd.install) begin
        for (int j = 0; j < POOL_FRAMES; j++) begin
          if (IW'(j) == ins_pos) begin
            order_list[j] <= IW'(fsel);
          end else if (IW'(j) > ins_pos) begin
            order_list[j] <= order_list[(j + POOL_FRAMES - 1) % POOL_FRAMES];
          end
        end
        len               <= len + 1'b1;
        frame_valid[fsel] <= 1'b1;
        frame_dirty[fsel] <= 1'b0;
        frame_old[fsel]   <= 1'b1;
      end
      if (cmd.unfix_upd && mark_r) begin
        log_counter       <= log_inc;
        frame_dirty[fsel] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      frame        <= kind ? unfix_frame : 4'd0;
      hit          <= 1'b0;
      failed       <= 1'b0;
      evicted      <= 1'b0;
      evicted_page <= '0;
      wrote_back   <= 1'b0;
      log_number   <= '0;
    end else begin
      if (cmd.hit_upd) begin
        frame <= fsel_ext[3:0];
        hit   <= 1'b1;
      end
      if (cmd.res_fail) begin
        failed <= 1'b1;
      end
      if (cmd.evict) begin
        evicted      <= 1'b1;
        evicted_page <= page_rdata;
        if (frame_dirty[fsel]) begin
          wrote_back <= 1'b1;
          log_number <= log_inc;
        end
      end
      if (cmd.install) begin
        frame <= fsel_ext[3:0];
      end
      if (cmd.unfix_upd && mark_r) begin
        log_number <= log_inc;
      end
    end
  end

endmodule

[src/midpoint_lru_frame_manager.sv]
// ----------------------------------------------------------------------------
// midpoint_lru_frame_manager
// Page-frame pool with midpoint-insertion LRU replacement.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; the result appears
// for one cycle with done high and cannot be stalled, so capture it then.
// An unfix of a resident frame passes through the update state before done;
// any other unfix goes straight to done. A fix walks the frame table one
// frame a cycle; on a hit on an old frame it then walks the recency list to
// find the frame and moves it to the head. A miss that takes a free frame
// installs it directly; otherwise the victim scan, one list entry a cycle
// over the old part and then the whole list, evicts an unpinned frame or
// fails when all are pinned. Busy drops in the cycle after done. The
// midpoint follows a configuration write through the old_pct, prod and
// scaled registers, well before any request reads it.
// ----------------------------------------------------------------------------
module midpoint_lru_frame_manager #(
  parameter int POOL_FRAMES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [30:0] page_id,
  input  logic [3:0]  unfix_frame,
  input  logic        mark_dirty,
  input  logic        old_percent_we,
  input  logic [6:0]  old_percent,
  output logic        done,
  output logic [3:0]  frame,
  output logic        hit,
  output logic        failed,
  output logic        evicted,
  output logic [30:0] evicted_page,
  output logic        wrote_back,
  output logic [31:0] log_number
);

  mlru_pkg::cmd_t cmd;
  mlru_pkg::sts_t sts;

  mlru_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .sts   (sts),
    .cmd   (cmd)
  );

  mlru_dp #(.POOL_FRAMES(POOL_FRAMES)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .kind           (kind),
    .page_id        (page_id),
    .unfix_frame    (unfix_frame),
    .mark_dirty     (mark_dirty),
    .old_percent_we (old_percent_we),
    .old_percent    (old_percent),
    .cmd            (cmd),
    .sts            (sts),
    .frame          (frame),
    .hit            (hit),
    .failed         (failed),
    .evicted        (evicted),
    .evicted_page   (evicted_page),
    .wrote_back     (wrote_back),
    .log_number     (log_number)
  );

endmodule

[dv/tb_midpoint_lru_frame_manager.sv]
// ----------------------------------------------------------------------------
// tb_midpoint_lru_frame_manager
// Self-checking bench for the midpoint LRU frame manager. A directed table
// covers reset, page id extremes, hits, dirty unfix, unfix of empty frames,
// eviction and the all-pinned failure. A pin saturation burst follows. The
// random phases then sweep the old share register, including zero, 100 and
// a value above 100. Results are checked field by field: typed rows against
// the table, the rest against a model of the frame table and recency list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_midpoint_lru_frame_manager;

  localparam int NFR = 16;
  localparam int NONE = NFR;
  localparam logic KIND_FIX = 1'b0;
  localparam logic KIND_UNFIX = 1'b1;
  localparam int WATCH_LIMIT = 5000;

  typedef struct packed {
    logic [3:0]  frame;
    logic        hit;
    logic        failed;
    logic        evicted;
    logic [30:0] evicted_page;
    logic        wrote_back;
    logic [31:0] log_number;
  } fm_res_t;

  typedef struct {
    logic        kind;
    logic [30:0] page;
    logic [3:0]  fidx;
    logic        mark;
    bit          typed;
    fm_res_t     res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic kind = 1'b0;
  logic [30:0] page_id = '0;
  logic [3:0] unfix_frame = '0;
  logic mark_dirty = 1'b0;
  logic old_percent_we = 1'b0;
  logic [6:0] old_percent = '0;
  logic done;
  logic [3:0] frame;
  logic hit, failed, evicted, wrote_back;
  logic [30:0] evicted_page;
  logic [31:0] log_number;

  midpoint_lru_frame_manager dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // frame table model
  logic [30:0] pg [NFR];
  logic        vld [NFR];
  logic [7:0]  pins [NFR];
  logic        dty [NFR];
  logic        old_f [NFR];
  int          ord [NFR];
  int          fstk [NFR];
  int          fcnt;
  logic [31:0] logc;
  logic [6:0]  pct;

  fm_res_t pending_q [$];
  row_t rows [$];
  int errors = 0;
  int idle_pct = 0;
  int quiet = 0;
  logic [30:0] page_pool [24];

  function automatic int midpoint_pos();
    int p;
    p = (pct > mlru_pkg::PCT_MAX) ? 100 : int'(pct);
    return (NFR * (100 - p)) / 100;
  endfunction

  function automatic int list_len();
    int n;
    n = 0;
    while (n < NFR && ord[n] != NONE) n++;
    return n;
  endfunction

  function automatic void list_remove(int fr);
    for (int i = 0; i < NFR; i++) begin
      if (ord[i] == fr) begin
        for (int j = i; j + 1 < NFR; j++) ord[j] = ord[j + 1];
        ord[NFR - 1] = NONE;
        return;
      end
    end
  endfunction

  function automatic void list_insert(int pos, int fr);
    if (pos >= NFR) pos = NFR - 1;
    for (int i = NFR - 1; i > pos; i--) ord[i] = ord[i - 1];
    ord[pos] = fr;
  endfunction

  function automatic int choose_victim();
    int len, mid, fr;
    len = list_len();
    mid = midpoint_pos();
    if (fcnt > 0) begin
      fcnt--;
      return fstk[fcnt];
    end
    for (int i = len; i > mid; i--) begin
      fr = ord[i - 1];
      if (fr < NFR && pins[fr] == 8'd0) return fr;
    end
    for (int i = len; i > 0; i--) begin
      fr = ord[i - 1];
      if (fr < NFR && pins[fr] == 8'd0) return fr;
    end
    return -1;
  endfunction

  function automatic fm_res_t apply_request(logic k, logic [30:0] p, logic [3:0] fi,
                                            logic m);
    fm_res_t r;
    int v, len, pos;
    r = '0;
    if (k == KIND_UNFIX) begin
      r.frame = fi;
      if (vld[fi]) begin
        if (pins[fi] > 8'd0) pins[fi]--;
        if (m) begin
          logc += mlru_pkg::LOG_STEP;
          dty[fi] = 1'b1;
          r.log_number = logc;
        end
      end
      return r;
    end
    for (int i = 0; i < NFR; i++) begin
      if (vld[i] && pg[i] == p) begin
        if (pins[i] < mlru_pkg::PIN_MAX) pins[i]++;
        if (old_f[i]) begin
          list_remove(i);
          list_insert(0, i);
          old_f[i] = 1'b0;
        end
        r.frame = i[3:0];
        r.hit = 1'b1;
        return r;
      end
    end
    v = choose_victim();
    if (v < 0) begin
      r.failed = 1'b1;
      return r;
    end
    if (vld[v]) begin
      if (dty[v]) begin
        logc += mlru_pkg::LOG_STEP;
        r.wrote_back = 1'b1;
        r.log_number = logc;
      end
      r.evicted = 1'b1;
      r.evicted_page = pg[v];
      list_remove(v);
    end
    pg[v] = p;
    vld[v] = 1'b1;
    pins[v] = 8'd1;
    dty[v] = 1'b0;
    len = list_len();
    pos = midpoint_pos();
    if (pos > len) pos = len;
    list_insert(pos, v);
    old_f[v] = 1'b1;
    r.frame = v[3:0];
    return r;
  endfunction

  task automatic report(string fld, logic [31:0] got, logic [31:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $realtime, fld, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    fm_res_t e;
    if (!rst && ((start && !busy) || done)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCH_LIMIT) begin
      $display("midpoint_lru_frame_manager: mismatch");
      $finish;
    end
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        report("unexpected result frame", 32'(frame), 32'd0);
      end else begin
        e = pending_q.pop_front();
        if (frame !== e.frame) report("frame", 32'(frame), 32'(e.frame));
        if (hit !== e.hit) report("hit", 32'(hit), 32'(e.hit));
        if (failed !== e.failed) report("failed", 32'(failed), 32'(e.failed));
        if (evicted !== e.evicted) report("evicted", 32'(evicted), 32'(e.evicted));
        if (evicted_page !== e.evicted_page)
          report("evicted_page", 32'(evicted_page), 32'(e.evicted_page));
        if (wrote_back !== e.wrote_back)
          report("wrote_back", 32'(wrote_back), 32'(e.wrote_back));
        if (log_number !== e.log_number) report("log_number", log_number, e.log_number);
      end
    end
  end

  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic issue(logic k, logic [30:0] p, logic [3:0] fi, logic m, bit typed,
                       fm_res_t want);
    fm_res_t r;
    idle_gap();
    start <= 1'b1;
    kind <= k;
    page_id <= p;
    unfix_frame <= fi;
    mark_dirty <= m;
    do @(posedge clk); while (busy);
    r = apply_request(k, p, fi, m);
    pending_q.push_back(typed ? want : r);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_share(logic [6:0] v);
    drain();
    old_percent_we <= 1'b1;
    old_percent <= v;
    @(posedge clk);
    old_percent_we <= 1'b0;
    pct = v;
    repeat (4) @(posedge clk);
  endtask

  function automatic void add_row(logic k, logic [30:0] p, logic [3:0] fi, logic m,
                                  bit typed, fm_res_t r);
    row_t w;
    w.kind = k; w.page = p; w.fidx = fi; w.mark = m; w.typed = typed; w.res = r;
    rows.push_back(w);
  endfunction

  function automatic fm_res_t mk(logic [3:0] f, logic h, logic fl, logic [31:0] ln);
    fm_res_t r;
    r = '0;
    r.frame = f; r.hit = h; r.failed = fl; r.log_number = ln;
    return r;
  endfunction

  initial begin
    fm_res_t r;
    logic [30:0] p;
    logic [6:0] shares [8] = '{7'd37, 7'd0, 7'd100, 7'd127, 7'd50, 7'd1, 7'd99, 7'd75};
    int modes [8] = '{0, 79, 8, 0, 79, 8, 0, 79};

    for (int i = 0; i < NFR; i++) begin
      pg[i] = '0; vld[i] = 1'b0; pins[i] = '0; dty[i] = 1'b0; old_f[i] = 1'b0;
      ord[i] = NONE; fstk[i] = NFR - 1 - i;
    end
    fcnt = NFR;
    logc = '0;
    pct = mlru_pkg::PCT_RESET;

    page_pool[0] = '0;
    page_pool[1] = 31'h7FFF_FFFF;
    for (int i = 2; i < 24; i++) page_pool[i] = 31'($urandom);

    r = '0;
    add_row(KIND_UNFIX, 31'h0, 4'd3, 1'b1, 1'b1, mk(4'd3, 1'b0, 1'b0, 32'd0));
    add_row(KIND_FIX, 31'h7FFF_FFFF, 4'd0, 1'b0, 1'b1, mk(4'd0, 1'b0, 1'b0, 32'd0));
    add_row(KIND_FIX, 31'h0, 4'd15, 1'b1, 1'b1, mk(4'd1, 1'b0, 1'b0, 32'd0));
    add_row(KIND_FIX, 31'h7FFF_FFFF, 4'd0, 1'b0, 1'b1, mk(4'd0, 1'b1, 1'b0, 32'd0));
    add_row(KIND_UNFIX, 31'h7FFF_FFFF, 4'd0, 1'b1, 1'b1, mk(4'd0, 1'b0, 1'b0, 32'd10));
    add_row(KIND_UNFIX, 31'h0, 4'd1, 1'b0, 1'b1, mk(4'd1, 1'b0, 1'b0, 32'd0));
    add_row(KIND_UNFIX, 31'h0, 4'd1, 1'b0, 1'b1, mk(4'd1, 1'b0, 1'b0, 32'd0));
    add_row(KIND_UNFIX, 31'h0, 4'd15, 1'b1, 1'b1, mk(4'd15, 1'b0, 1'b0, 32'd0));
    for (int i = 1; i <= 14; i++)
      add_row(KIND_FIX, 31'h4000_0000 | 31'(i), 4'd0, 1'b0, 1'b0, r);
    add_row(KIND_FIX, 31'h2AAA_AAAA, 4'd0, 1'b0, 1'b0, r);
    add_row(KIND_FIX, 31'h5555_5555, 4'd0, 1'b0, 1'b1, mk(4'd0, 1'b0, 1'b1, 32'd0));
    add_row(KIND_UNFIX, 31'h0, 4'd5, 1'b1, 1'b0, r);
    add_row(KIND_FIX, 31'h5555_5555, 4'd0, 1'b0, 1'b0, r);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i])
      issue(rows[i].kind, rows[i].page, rows[i].fidx, rows[i].mark, rows[i].typed,
            rows[i].res);
    repeat (260) issue(KIND_FIX, 31'h7FFF_FFFF, 4'd0, 1'b0, 1'b0, r);
    repeat (3) issue(KIND_UNFIX, 31'h0, 4'd0, 1'b1, 1'b0, r);

    for (int ph = 0; ph < 8; ph++) begin
      set_share(shares[ph]);
      idle_pct = modes[ph];
      for (int n = 0; n < 165; n++) begin
        if ($urandom_range(99) < 35) begin
          issue(KIND_UNFIX, 31'($urandom), 4'($urandom), 1'($urandom), 1'b0, r);
        end else begin
          p = ($urandom_range(9) == 0) ? 31'($urandom)
              : page_pool[$urandom_range(ph[0] ? 23 : 19)];
          issue(KIND_FIX, p, 4'($urandom), 1'($urandom), 1'b0, r);
        end
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("midpoint_lru_frame_manager: match");
    else
      $display("midpoint_lru_frame_manager: mismatch");
    $finish;
  end

endmodule

[filelist.f]
src/mlru_pkg.sv
src/mlru_ram.sv
src/mlru_ctrl.sv
src/mlru_dp.sv
src/midpoint_lru_frame_manager.sv
dv/tb_midpoint_lru_frame_manager.sv
